// File: src/dmxr_pkg.sv
package dmxr_pkg;

    // Field and register widths
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned BIT_W   = 8;
    localparam int unsigned BRK_W   = 16;
    localparam int unsigned CHAN_W  = 9;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned CFG_AW  = 2;
    localparam int unsigned CFG_DW  = 16;
    localparam int unsigned BIDX_W  = 4;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_BIT_TICKS     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BREAK_TICKS   = 2'd2;

    // Input action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Receiver phases
    typedef enum logic [2:0] {
        PH_WAIT_BREAK,
        PH_IN_BREAK,
        PH_WAIT_START,
        PH_RECV,
        PH_WAIT_STOP
    } t_rx_phase;

    // Effective receiver settings: count clamped to the channel limit, zero tick values mapped to one
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BIT_W-1:0]   bit_ticks;
        logic [BRK_W-1:0]   brk_ticks;
    } t_rx_cfg;

    // Channel store write request
    typedef struct packed {
        logic              en;
        logic [CHAN_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_store_wr;

endpackage

// File: src/dmxr_ifs.sv
interface dmxr_in_if import dmxr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic              line_level;
    logic [CHAN_W-1:0] channel;

    modport source (output valid, action, line_level, channel, input ready);
    modport sink   (input valid, action, line_level, channel, output ready);
endinterface

interface dmxr_out_if import dmxr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_value;
    logic              frame_done;

    modport source (output valid, read_value, frame_done, input ready);
    modport sink   (input valid, read_value, frame_done, output ready);
endinterface

interface dmxr_cfg_if import dmxr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: src/dmxr_rx.sv
module dmxr_rx import dmxr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic               i_level,
    input  t_rx_cfg            i_cfg,
    output logic               o_frame_done,
    output t_store_wr          o_wr,
    output logic [COUNT_W-1:0] o_slot_index
);

    t_rx_phase          r_phase, n_phase;
    logic [BRK_W-1:0]   r_tick_cnt, n_tick_cnt;
    logic [BIDX_W-1:0]  r_bit_idx, n_bit_idx;
    logic [DATA_W-1:0]  r_shift, n_shift;
    logic [COUNT_W-1:0] r_slot, n_slot;
    logic               r_sc_pend, n_sc_pend;

    logic [BRK_W-1:0]   low_cnt;
    logic [BRK_W-1:0]   dec_cnt;
    logic [DATA_W-1:0]  shifted;
    logic [BIDX_W-1:0]  bit_inc;
    logic [COUNT_W-1:0] slot_after;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT_BREAK;
            r_tick_cnt <= '0;
            r_bit_idx  <= '0;
            r_shift    <= '0;
            r_slot     <= '0;
            r_sc_pend  <= 1'b1;
        end else if (i_tick) begin
            r_phase    <= n_phase;
            r_tick_cnt <= n_tick_cnt;
            r_bit_idx  <= n_bit_idx;
            r_shift    <= n_shift;
            r_slot     <= n_slot;
            r_sc_pend  <= n_sc_pend;
        end
    end

    // Next state for one line sample
    always_comb begin
        n_phase      = r_phase;
        n_tick_cnt   = r_tick_cnt;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_slot       = r_slot;
        n_sc_pend    = r_sc_pend;
        o_frame_done = 1'b0;
        o_wr.en      = 1'b0;
        o_wr.addr    = r_slot[CHAN_W-1:0];
        o_wr.data    = {i_level, r_shift[DATA_W-1:1]};

        low_cnt    = (r_tick_cnt != '1) ? r_tick_cnt + 1'b1 : r_tick_cnt;
        dec_cnt    = (r_tick_cnt != '0) ? r_tick_cnt - 1'b1 : r_tick_cnt;
        shifted    = {i_level, r_shift[DATA_W-1:1]};
        bit_inc    = r_bit_idx + 1'b1;
        slot_after = r_slot;

        unique case (r_phase)
            PH_WAIT_BREAK: begin
                if (i_level) begin
                    n_tick_cnt = '0;
                end else if (low_cnt >= i_cfg.brk_ticks) begin
                    // Break seen: empty the store by dropping the fill count
                    n_slot     = '0;
                    n_sc_pend  = 1'b1;
                    n_tick_cnt = '0;
                    n_phase    = PH_IN_BREAK;
                end else begin
                    n_tick_cnt = low_cnt;
                end
            end
            PH_IN_BREAK: begin
                if (i_level) n_phase = PH_WAIT_START;
            end
            PH_WAIT_START: begin
                if (!i_level) begin
                    // Aim the first sample at the middle of data bit 0
                    n_tick_cnt = BRK_W'(i_cfg.bit_ticks) + BRK_W'(i_cfg.bit_ticks >> 1);
                    n_bit_idx  = '0;
                    n_shift    = '0;
                    n_phase    = PH_RECV;
                end
            end
            PH_RECV: begin
                n_tick_cnt = dec_cnt;
                if (dec_cnt == '0) begin
                    n_shift   = shifted;
                    n_bit_idx = bit_inc;
                    if (bit_inc >= BIDX_W'(8)) begin
                        // Slot complete: drop the start code, store the rest
                        if (r_sc_pend) begin
                            n_sc_pend = 1'b0;
                        end else if (r_slot < i_cfg.count) begin
                            o_wr.en    = 1'b1;
                            slot_after = r_slot + 1'b1;
                        end
                        n_slot = slot_after;
                        if (slot_after >= i_cfg.count) begin
                            n_phase      = PH_WAIT_BREAK;
                            n_tick_cnt   = '0;
                            o_frame_done = 1'b1;
                        end else begin
                            n_phase = PH_WAIT_STOP;
                        end
                    end else begin
                        n_tick_cnt = BRK_W'(i_cfg.bit_ticks);
                    end
                end
            end
            PH_WAIT_STOP: begin
                if (i_level) n_phase = PH_WAIT_START;
            end
            default: begin
                n_phase    = PH_WAIT_BREAK;
                n_tick_cnt = '0;
            end
        endcase

        o_wr.en = o_wr.en & i_tick;
    end

    assign o_slot_index = r_slot;

endmodule

// File: src/dmxr_store.sv
module dmxr_store import dmxr_pkg::*; #(
    parameter int unsigned DEPTH = 512
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [CHAN_W-1:0]  i_rd_addr,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [COUNT_W-1:0] i_fill,
    input  t_store_wr          i_wr,
    output logic [DATA_W-1:0]  o_rd_value
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_hit;
    logic              rd_hit;

    // Entries at or beyond the fill count or channel count read as zero
    assign rd_hit = (COUNT_W'(i_rd_addr) < i_count) && (COUNT_W'(i_rd_addr) < i_fill);

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) mem[i_wr.addr[AW-1:0]] <= i_wr.data;
    end

    // Registered read port; hold while the result waits
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr[AW-1:0]];
            r_rd_hit  <= rd_hit;
        end
    end

    assign o_rd_value = r_rd_hit ? r_rd_data : '0;

endmodule

// File: src/dmx512_frame_receiver_top.sv
// A result passes through the stage 1 register and then the output register.
// Throughput: one item per cycle unless o_out.ready stalls the output.
// The channel store has one write and one registered read port.
// Reset clears the rx state, the pipeline and the registers to their defaults.
// The store is not swept: entries at or beyond the fill count read as zero.
module dmx512_frame_receiver_top import dmxr_pkg::*; #(
    parameter int unsigned MAX_CHANNELS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmxr_in_if.sink     i_in,
    dmxr_cfg_if.sink    i_cfg,
    dmxr_out_if.source  o_out
);

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CHANNELS);

    logic [COUNT_W-1:0] r_count;
    logic [BIT_W-1:0]   r_bit_ticks;
    logic [BRK_W-1:0]   r_brk_ticks;

    t_rx_cfg            rx_cfg;
    t_store_wr          st_wr;
    logic [COUNT_W-1:0] slot_index;
    logic [DATA_W-1:0]  rd_value;
    logic               rx_done;

    logic               in_xfer;
    logic               s1_adv;
    logic               r_s1_valid;
    logic               r_s1_read;
    logic               r_s1_done;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_value;
    logic               r_out_done;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_W'(512);
            r_bit_ticks <= BIT_W'(16);
            r_brk_ticks <= BRK_W'(352);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                CFG_CHANNEL_COUNT: r_count     <= i_cfg.data[COUNT_W-1:0];
                CFG_BIT_TICKS:     r_bit_ticks <= i_cfg.data[BIT_W-1:0];
                CFG_BREAK_TICKS:   r_brk_ticks <= i_cfg.data[BRK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective settings
    assign rx_cfg.count     = (r_count > MAX_COUNT) ? MAX_COUNT : r_count;
    assign rx_cfg.bit_ticks = (r_bit_ticks == '0) ? BIT_W'(1) : r_bit_ticks;
    assign rx_cfg.brk_ticks = (r_brk_ticks == '0) ? BRK_W'(1) : r_brk_ticks;

    // Handshake: advance stage 1 when the output register frees up
    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in.valid && i_in.ready;

    dmxr_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (in_xfer && (i_in.action == ACT_TICK)),
        .i_level      (i_in.line_level),
        .i_cfg        (rx_cfg),
        .o_frame_done (rx_done),
        .o_wr         (st_wr),
        .o_slot_index (slot_index)
    );

    dmxr_store #(
        .DEPTH (MAX_CHANNELS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (in_xfer && (i_in.action == ACT_READ)),
        .i_rd_addr  (i_in.channel),
        .i_count    (rx_cfg.count),
        .i_fill     (slot_index),
        .i_wr       (st_wr),
        .o_rd_value (rd_value)
    );

    // Stage 1: memory read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_read <= (i_in.action == ACT_READ);
            r_s1_done <= (i_in.action == ACT_TICK) && rx_done;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_value <= r_s1_read ? rd_value : '0;
            r_out_done  <= r_s1_done;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_value;
    assign o_out.frame_done = r_out_done;

endmodule
